### sv/sroi_pkg.sv
// Package: shared constants and control types for the ROI spectrum sum block.
`default_nettype none
package sroi_pkg;

  localparam int MAX_CHANNELS = 4096;
  localparam int ADDR_W       = $clog2(MAX_CHANNELS);
  localparam int CHAN_W       = 12;
  localparam int COUNT_W      = 32;
  localparam int SUM_W        = 44;
  localparam int ENERGY_W     = 32;
  localparam int HW_W         = 31;
  localparam int SLOPE_W      = 31;
  localparam int NCH_W        = 13;
  localparam int NUM_W        = 35;
  localparam int DIV_W        = 34;
  localparam int DIVS_W       = SLOPE_W + 1;
  localparam int STEP_W       = $clog2(DIV_W);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_W - 1);

  localparam logic [ENERGY_W-1:0] OFFSET_RST = '0;
  localparam logic [SLOPE_W-1:0]  SLOPE_RST  = SLOPE_W'(10486);
  localparam logic [NCH_W-1:0]    NCH_RST    = NCH_W'(2048);

  typedef enum logic [1:0] {
    CFG_ZERO_OFS      = 2'd0,
    CFG_KEV_PER_CH    = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic div_load_l;
    logic div_load_r;
    logic div_step;
    logic clamp;
    logic walk;
    logic emit;
  } sroi_cmd_t;

  typedef struct packed {
    logic walk_last;
  } sroi_status_t;

endpackage
`default_nettype wire

### sv/sroi_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module sroi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

### sv/sroi_datapath.sv
// Datapath: config registers, edge divider, clamping, spectrum store and window accumulator.
`default_nettype none
module sroi_datapath import sroi_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [ENERGY_W-1:0]   cfg_data,
  input  wire logic [CHAN_W-1:0]     in_channel,
  input  wire logic [COUNT_W-1:0]    in_count,
  input  wire logic [ENERGY_W-1:0]   in_center,
  input  wire logic [HW_W-1:0]       in_half_width,
  input  wire sroi_cmd_t             cmd,
  output sroi_status_t               status,
  output logic      [SUM_W-1:0]      out_roi_sum,
  output logic      [CHAN_W-1:0]     out_left_channel,
  output logic      [CHAN_W-1:0]     out_right_channel
);

  logic [ENERGY_W-1:0] offset_r;
  logic [SLOPE_W-1:0]  slope_r;
  logic [NCH_W-1:0]    nch_r;

  logic [NUM_W-1:0]    num_l_r, num_r_r;
  logic [DIV_W-1:0]    dq_r;
  logic [DIVS_W-1:0]   rem_r;
  logic                neg_r;
  logic [DIV_W-1:0]    q_l_r;
  logic [CHAN_W-1:0]   left_r, right_r;
  logic [ADDR_W-1:0]   addr_r;
  logic                acc_en_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W-1:0]    roi_sum_r;
  logic [CHAN_W-1:0]   left_out_r, right_out_r;

  logic [SLOPE_W-1:0]  den;
  logic [DIVS_W-1:0]   dvs;
  logic [NUM_W-1:0]    num_sel, mag;
  logic [NUM_W-1:0]    dvd_full;
  logic [DIVS_W:0]     rem_sh;
  logic                ge;
  logic [DIVS_W:0]     rem_sub;
  logic [NUM_W-1:0]    c_ext, h_ext, o_ext;
  logic [NCH_W-1:0]    n_eff;
  logic [DIV_W-1:0]    q_r;
  logic [CHAN_W-1:0]   right_c, left_c;
  logic [ADDR_W-1:0]   ram_addr;
  logic                ram_we;
  logic [COUNT_W-1:0]  ram_rdata;

  assign den      = (slope_r == '0) ? SLOPE_W'(1) : slope_r;
  assign dvs      = {den, 1'b0};
  assign num_sel  = cmd.div_load_r ? num_r_r : num_l_r;
  assign mag      = num_sel[NUM_W-1] ? (~num_sel + NUM_W'(1)) : num_sel;
  assign dvd_full = {mag[NUM_W-2:0], 1'b0} + NUM_W'(den);

  assign rem_sh  = {rem_r, dq_r[DIV_W-1]};
  assign ge      = (rem_sh >= {1'b0, dvs});
  assign rem_sub = rem_sh - {1'b0, dvs};

  assign c_ext = {{(NUM_W-ENERGY_W){in_center[ENERGY_W-1]}}, in_center};
  assign h_ext = NUM_W'(in_half_width);
  assign o_ext = {{(NUM_W-ENERGY_W){offset_r[ENERGY_W-1]}}, offset_r};

  always_comb begin
    if (nch_r < NCH_W'(2)) begin
      n_eff = NCH_W'(2);
    end else if (nch_r > NCH_W'(MAX_CHANNELS)) begin
      n_eff = NCH_W'(MAX_CHANNELS);
    end else begin
      n_eff = nch_r;
    end
  end

  assign q_r = neg_r ? '0 : dq_r;

  always_comb begin
    if (q_r >= DIV_W'(n_eff)) begin
      right_c = CHAN_W'(n_eff - NCH_W'(2));
    end else begin
      right_c = q_r[CHAN_W-1:0];
    end
    if (q_l_r > DIV_W'(right_c)) begin
      left_c = (right_c == '0) ? '0 : right_c - CHAN_W'(1);
    end else begin
      left_c = q_l_r[CHAN_W-1:0];
    end
  end

  assign ram_we   = cmd.load && (32'(in_channel) < MAX_CHANNELS);
  assign ram_addr = cmd.walk ? addr_r : in_channel[ADDR_W-1:0];

  sroi_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(MAX_CHANNELS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_count),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RST;
      slope_r  <= SLOPE_RST;
      nch_r    <= NCH_RST;
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= cmd.walk;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ZERO_OFS:      offset_r <= cfg_data;
          CFG_KEV_PER_CH:    slope_r  <= cfg_data[SLOPE_W-1:0];
          CFG_CHANNEL_COUNT: nch_r    <= cfg_data[NCH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      num_l_r <= c_ext - h_ext - o_ext;
      num_r_r <= c_ext + h_ext - o_ext;
    end
    if (cmd.div_load_l || cmd.div_load_r) begin
      dq_r  <= dvd_full[DIV_W-1:0];
      rem_r <= '0;
      neg_r <= num_sel[NUM_W-1];
    end else if (cmd.div_step) begin
      dq_r  <= {dq_r[DIV_W-2:0], ge};
      rem_r <= ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
    end
    if (cmd.div_load_r) begin
      q_l_r <= q_r;
    end
    if (cmd.clamp) begin
      left_r  <= left_c;
      right_r <= right_c;
      addr_r  <= ADDR_W'(left_c);
      sum_r   <= '0;
    end else begin
      if (cmd.walk) begin
        addr_r <= addr_r + ADDR_W'(1);
      end
      if (acc_en_r) begin
        sum_r <= sum_r + SUM_W'(ram_rdata);
      end
    end
    if (cmd.emit) begin
      roi_sum_r   <= sum_r;
      left_out_r  <= left_r;
      right_out_r <= right_r;
    end
  end

  assign status.walk_last  = (CHAN_W'(addr_r) == right_r);
  assign out_roi_sum       = roi_sum_r;
  assign out_left_channel  = left_out_r;
  assign out_right_channel = right_out_r;

`ifndef SYNTHESIS
  a_clamp_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clamp |=> (left_r <= right_r)) else $error("left edge past right edge");
  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clamp |=> (NCH_W'(right_r) < n_eff)) else $error("right edge beyond channel count");
  a_walk_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk |-> (CHAN_W'(addr_r) <= right_r)) else $error("walk ran past window");
`endif

endmodule
`default_nettype wire

### sv/sroi_ctrl.sv
// Controller: sequences load, the left and right edge divisions, clamping, window walk and result.
`default_nettype none
module sroi_ctrl import sroi_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         in_kind,
  input  wire logic         out_ready,
  input  wire sroi_status_t status,
  output logic              in_ready,
  output logic              out_valid,
  output sroi_cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_L,
    ST_DIV_L,
    ST_INIT_R,
    ST_DIV_R,
    ST_CLAMP,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind) begin
            cmd.capture = 1'b1;
            state_nxt   = ST_INIT_L;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_INIT_L: begin
        cmd.div_load_l = 1'b1;
        cnt_nxt        = '0;
        state_nxt      = ST_DIV_L;
      end
      ST_DIV_L: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + STEP_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_INIT_R;
        end
      end
      ST_INIT_R: begin
        cmd.div_load_r = 1'b1;
        cnt_nxt        = '0;
        state_nxt      = ST_DIV_R;
      end
      ST_DIV_R: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + STEP_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (status.walk_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind) |=> (state_r == ST_INIT_L && !in_ready))
    else $error("query accept did not start sequence");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_R && cnt_r == DIV_LAST) |=> (state_r == ST_CLAMP))
    else $error("division length mismatch");
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FINISH))
    else $error("result raised outside finish");
`endif

endmodule
`default_nettype wire

### sv/spectrum_roi_window_sum_core.sv
// Top level: region-of-interest spectrum sum core.
// Usage:
//   Input channel (in_valid/in_ready): in_kind 0 loads in_count into spectrum
//   channel in_channel and gives no result. in_kind 1 is a query:
//   the window edges are computed from in_center and in_half_width with the
//   configured calibration offset and gain, clamped to channel_count, and
//   the counts from left to right inclusive are summed.
//   Result channel (out_valid/out_ready): out_roi_sum, out_left_channel,
//   out_right_channel, one item per query, held in an output register.
//   Config port: cfg_we writes register cfg_index (0 offset, 1 slope,
//   2 channel count) with cfg_data; write only while idle.
//   Sequence: a query runs two bit-serial divisions (a load plus 34 steps
//   each) that share one divider, then the store reads one channel a cycle
//   from left to right. The result is registered, and the next item is
//   taken in the same cycle that the result becomes valid.
//   A new item is taken while a finished result still waits; if the receiver
//   stalls, a second query holds in its last step until the register frees.
//   Reset: synchronous, active low; config returns to its reset values, the
//   spectrum store is not cleared and must be loaded before it is queried.
`default_nettype none
module spectrum_roi_window_sum_core import sroi_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [ENERGY_W-1:0] cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_kind,
  input  wire logic [CHAN_W-1:0]   in_channel,
  input  wire logic [COUNT_W-1:0]  in_count,
  input  wire logic [ENERGY_W-1:0] in_center,
  input  wire logic [HW_W-1:0]     in_half_width,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [SUM_W-1:0]    out_roi_sum,
  output logic      [CHAN_W-1:0]   out_left_channel,
  output logic      [CHAN_W-1:0]   out_right_channel
);

  sroi_cmd_t    cmd;
  sroi_status_t status;

  sroi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .out_ready(out_ready),
    .status   (status),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .cmd      (cmd)
  );

  sroi_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_channel       (in_channel),
    .in_count         (in_count),
    .in_center        (in_center),
    .in_half_width    (in_half_width),
    .cmd              (cmd),
    .status           (status),
    .out_roi_sum      (out_roi_sum),
    .out_left_channel (out_left_channel),
    .out_right_channel(out_right_channel)
  );

endmodule
`default_nettype wire

### test/spectrum_roi_window_sum_core_tb.sv
// Testbench for the ROI spectrum sum core: predicted window sums under random handshake timing.
import sroi_pkg::*;

typedef enum logic {
  ITEM_LOAD  = 1'b0,
  ITEM_QUERY = 1'b1
} item_kind_t;

class roi_sum_scoreboard;
  typedef struct {
    logic [SUM_W-1:0]  sum;
    logic [CHAN_W-1:0] left;
    logic [CHAN_W-1:0] right;
  } roi_result_t;

  logic signed [ENERGY_W-1:0] offset;
  logic [SLOPE_W-1:0]         slope;
  logic [NCH_W-1:0]           nch;
  bit [COUNT_W-1:0]           spectrum [MAX_CHANNELS];
  bit                         loaded [MAX_CHANNELS];
  roi_result_t                pending_sums [$];
  int                         errors;

  function new();
    offset = '0;
    slope  = SLOPE_W'(10486);
    nch    = NCH_W'(2048);
    errors = 0;
  endfunction

  task report(string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function void set_reg(cfg_idx_t idx, logic [31:0] data);
    case (idx)
      CFG_ZERO_OFS:      offset = data;
      CFG_KEV_PER_CH:    slope = data[SLOPE_W-1:0];
      CFG_CHANNEL_COUNT: nch = data[NCH_W-1:0];
      default: ;
    endcase
  endfunction

  // half away from zero; anything below zero lands on channel 0
  function longint unsigned round_edge(longint num, longint unsigned den);
    longint unsigned mag;
    if (num < 0) return 0;
    mag = num;
    return (2 * mag + den) / (2 * den);
  endfunction

  function void predict_window(logic signed [31:0] center, logic [30:0] hw,
                               output int unsigned lo, output int unsigned hi);
    longint unsigned n, den, l, r;
    longint c, w, off;
    n = nch;
    if (n < 2) n = 2;
    if (n > MAX_CHANNELS) n = MAX_CHANNELS;
    den = slope;
    if (den == 0) den = 1;
    c = center;
    w = hw;
    off = offset;
    l = round_edge(c - w - off, den);
    r = round_edge(c + w - off, den);
    if (r >= n) r = n - 2;
    if (l > r) l = (r == 0) ? 0 : r - 1;
    lo = l;
    hi = r;
  endfunction

  function void note_item(item_kind_t kind, logic [CHAN_W-1:0] chan, logic [COUNT_W-1:0] cnt,
                          logic signed [31:0] center, logic [30:0] hw);
    roi_result_t res;
    int unsigned lo, hi, i;
    logic [SUM_W-1:0] acc;
    if (kind == ITEM_LOAD) begin
      spectrum[chan] = cnt;
      loaded[chan] = 1'b1;
      return;
    end
    predict_window(center, hw, lo, hi);
    acc = '0;
    for (i = lo; i <= hi; i++) acc += spectrum[i];
    res.sum = acc;
    res.left = CHAN_W'(lo);
    res.right = CHAN_W'(hi);
    pending_sums.push_back(res);
  endfunction

  task check_sum(logic [SUM_W-1:0] sum, logic [CHAN_W-1:0] l, logic [CHAN_W-1:0] r);
    roi_result_t want;
    if (pending_sums.size() == 0) begin
      report($sformatf("unexpected item sum=%0h left=%0d right=%0d", sum, l, r));
      return;
    end
    want = pending_sums.pop_front();
    if (sum !== want.sum)
      report($sformatf("roi_sum got %0h want %0h", sum, want.sum));
    if (l !== want.left)
      report($sformatf("left_channel got %0d want %0d", l, want.left));
    if (r !== want.right)
      report($sformatf("right_channel got %0d want %0d", r, want.right));
  endtask
endclass

module spectrum_roi_window_sum_core_tb;
  import sroi_pkg::*;

  localparam longint E_MAX = 64'sd2147483647;
  localparam longint E_MIN = -64'sd2147483648;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  cfg_idx_t            cfg_index = CFG_ZERO_OFS;
  logic [ENERGY_W-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  item_kind_t          in_kind = ITEM_LOAD;
  logic [CHAN_W-1:0]   in_channel = '0;
  logic [COUNT_W-1:0]  in_count = '0;
  logic [ENERGY_W-1:0] in_center = '0;
  logic [HW_W-1:0]     in_half_width = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SUM_W-1:0]    out_roi_sum;
  logic [CHAN_W-1:0]   out_left_channel;
  logic [CHAN_W-1:0]   out_right_channel;

  roi_sum_scoreboard sb;
  bit calm = 1'b0;
  int long_hold = 0;
  int stall_left = 0;
  int wide_left = 16;

  spectrum_roi_window_sum_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_channel(in_channel), .in_count(in_count), .in_center(in_center),
    .in_half_width(in_half_width),
    .out_valid(out_valid), .out_ready(out_ready), .out_roi_sum(out_roi_sum),
    .out_left_channel(out_left_channel), .out_right_channel(out_right_channel)
  );

  initial forever #5 clk = ~clk;

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stall bursts plus an optional long hold-off
  initial forever begin
    @(posedge clk);
    if (long_hold > 0) begin
      long_hold--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(99) < 8) begin
      stall_left = $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready)
      sb.check_sum(out_roi_sum, out_left_channel, out_right_channel);

  function automatic logic [31:0] sat_energy(longint v);
    if (v > E_MAX) return 32'h7FFF_FFFF;
    if (v < E_MIN) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [30:0] sat_width(longint v);
    if (v < 0) return '0;
    if (v > E_MAX) return '1;
    return v[30:0];
  endfunction

  function automatic logic [31:0] pick_count();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic longint edge_jitter(longint den);
    case ($urandom_range(3))
      0: return den / 2;
      1: return -(den / 2);
      2: return 0;
      default: return longint'($urandom_range(0, den)) - den / 2;
    endcase
  endfunction

  task automatic offer_item(item_kind_t kind, logic [CHAN_W-1:0] chan, logic [COUNT_W-1:0] cnt,
                            logic [31:0] center, logic [30:0] hw);
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_channel    <= chan;
    in_count      <= cnt;
    in_center     <= center;
    in_half_width <= hw;
    do @(posedge clk); while (!in_ready);
    sb.note_item(kind, chan, cnt, center, hw);
  endtask

  task automatic idle_input(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic maybe_idle_input();
    if (!calm && $urandom_range(99) < 25) idle_input($urandom_range(1, 13));
  endtask

  task automatic load_channel(logic [CHAN_W-1:0] chan, logic [COUNT_W-1:0] cnt);
    maybe_idle_input();
    offer_item(ITEM_LOAD, chan, cnt, $urandom, 31'($urandom));
  endtask

  // fill any unloaded channel of the window first, then query it
  task automatic query_window(logic [31:0] c, logic [30:0] h);
    int unsigned lo, hi, i;
    sb.predict_window(c, h, lo, hi);
    for (i = lo; i <= hi; i++)
      if (!sb.loaded[i]) load_channel(CHAN_W'(i), pick_count());
    maybe_idle_input();
    offer_item(ITEM_QUERY, CHAN_W'($urandom), $urandom, c, h);
  endtask

  task automatic random_roi_query();
    logic [31:0] c;
    logic [30:0] h;
    int unsigned lo, hi;
    longint n, den, c0, w, e_lo, e_hi;
    int t;
    bit ok;
    n = sb.nch;
    if (n < 2) n = 2;
    if (n > MAX_CHANNELS) n = MAX_CHANNELS;
    den = sb.slope;
    if (den == 0) den = 1;
    ok = 1'b0;
    for (t = 0; t < 20 && !ok; t++) begin
      if ($urandom_range(9) < 2) begin
        c = $urandom;
        h = 31'($urandom);
      end else begin
        case ($urandom_range(7))
          0: c0 = -longint'($urandom_range(1, 40));
          1: c0 = n - 1 + longint'($urandom_range(0, 40));
          default: c0 = longint'($urandom_range(0, (n > 96) ? 95 : n - 1));
        endcase
        w = ($urandom_range(7) == 0) ? longint'($urandom_range(13, 63))
                                     : longint'($urandom_range(0, 12));
        e_lo = sb.offset + den * c0 + edge_jitter(den);
        e_hi = sb.offset + den * (c0 + w) + edge_jitter(den);
        c = sat_energy((e_lo + e_hi) >>> 1);
        h = sat_width((e_hi - e_lo) >>> 1);
      end
      sb.predict_window(c, h, lo, hi);
      if (hi - lo <= 64) begin
        ok = 1'b1;
      end else if (wide_left > 0 && hi < 256) begin
        wide_left--;
        ok = 1'b1;
      end
    end
    if (!ok) begin
      c = sat_energy(sb.offset + den * longint'($urandom_range(0, (n > 96) ? 95 : n - 1)));
      h = '0;
    end
    query_window(c, h);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (sb.pending_sums.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_calibration(logic [31:0] off, logic [31:0] slp, logic [31:0] cnt);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ZERO_OFS;
    cfg_data  <= off;
    @(posedge clk);
    sb.set_reg(CFG_ZERO_OFS, off);
    cfg_index <= CFG_KEV_PER_CH;
    cfg_data  <= slp;
    @(posedge clk);
    sb.set_reg(CFG_KEV_PER_CH, slp);
    cfg_index <= CFG_CHANNEL_COUNT;
    cfg_data  <= cnt;
    @(posedge clk);
    sb.set_reg(CFG_CHANNEL_COUNT, cnt);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] off, slp, cnt;
    int ph, k, i;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset calibration
    load_channel(0, 32'hFFFF_FFFF);
    query_window(32'd0, 31'd0);

    // one keV per channel, eight channels
    wait_quiet();
    set_calibration(32'd0, 32'd1 << 20, 32'd8);
    load_channel(0, 32'hFFFF_FFFF);
    load_channel(1, 32'h0000_0000);
    load_channel(2, 32'h0000_0001);
    load_channel(3, 32'h8000_0000);
    load_channel(4, 32'hFFFF_FFFF);
    load_channel(5, 32'h1234_5678);
    load_channel(6, 32'hFFFF_FFFF);
    load_channel(7, 32'h7FFF_FFFF);
    load_channel(12'hFFF, 32'hFFFF_FFFF);
    query_window(32'd0, 31'd0);
    query_window((32'd3 << 20) + (32'd1 << 19), 31'd0);
    query_window(-(32'd1 << 19), 31'd0);
    query_window(32'h8000_0000, 31'h7FFF_FFFF);
    query_window(32'h7FFF_FFFF, 31'h7FFF_FFFF);
    query_window(32'h7FFF_FFFF, 31'd0);
    query_window(32'd2 << 20, 31'd1 << 20);
    query_window((32'd5 << 20) + (32'd1 << 19) - 32'd1, 31'd1 << 19);

    // two channels: right clamps to 0 and left floors at 0
    wait_quiet();
    set_calibration(32'd0, 32'd1 << 20, 32'd2);
    query_window(32'h7FFF_FFFF, 31'd0);

    for (ph = 0; ph < 12; ph++) begin
      wait_quiet();
      case (ph)
        0: begin off = 32'h8000_0000; slp = 32'd1;         cnt = 32'd4096; end
        1: begin off = 32'h7FFF_FFFF; slp = 32'h7FFF_FFFF; cnt = 32'd2;    end
        2: begin off = 32'd0;         slp = 32'd0;         cnt = 32'd1;    end
        3: begin off = $urandom;      slp = 32'd10486;     cnt = 32'd8191; end
        4: begin off = $urandom;      slp = 32'd1 << 20;   cnt = 32'd0;    end
        5: begin off = 32'd0;         slp = 32'd1 << 20;   cnt = 32'd64;   end
        default: begin
          case ($urandom_range(3))
            0: off = 32'd0;
            1: off = $urandom_range(0, 100 << 20);
            2: off = -$urandom_range(0, 100 << 20);
            default: off = $urandom;
          endcase
          case ($urandom_range(4))
            0: slp = 32'd10486;
            1: slp = 32'd1 << 20;
            2: slp = $urandom_range(1, 1 << 16);
            3: slp = $urandom_range(1 << 16, 1 << 24);
            default: slp = $urandom_range(1, 32'h7FFF_FFFF);
          endcase
          case ($urandom_range(5))
            0: cnt = 32'd4096;
            1: cnt = 32'd2;
            default: cnt = $urandom_range(2, 300);
          endcase
        end
      endcase
      set_calibration(off, slp, cnt);
      calm = (ph >= 10);
      if (ph == 5) begin
        for (i = 0; i < 64; i++)
          if (!sb.loaded[i]) load_channel(CHAN_W'(i), pick_count());
        // receiver holds off; queries back up until input stalls
        long_hold = 500;
        for (i = 0; i < 10; i++) random_roi_query();
      end
      for (k = 0; k < 35; k++) begin
        if ($urandom_range(99) < 55) random_roi_query();
        else load_channel(CHAN_W'($urandom_range(4095)), pick_count());
      end
    end

    wait_quiet();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending_sums.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

### filelist.f
sv/sroi_pkg.sv
sv/sroi_ram.sv
sv/sroi_datapath.sv
sv/sroi_ctrl.sv
sv/spectrum_roi_window_sum_core.sv
test/spectrum_roi_window_sum_core_tb.sv
